### rtl/apbc_pkg.sv
package apbc_pkg;

	// Default width of the fill counter
	localparam int unsigned FILL_WIDTH_DEF = 16;

	// Register reset values
	localparam logic [15:0] CAPACITY_RST = 16'd16384;
	localparam logic [15:0] TRIGGER_RST  = 16'd8192;
	localparam logic [12:0] CHUNK_RST    = 13'd512;
	localparam logic [6:0]  RECEIVES_RST = 7'd4;

	// Product of receives and chunk size: 7 x 13 bits
	localparam int unsigned BUDGET_W = 20;

	// Event codes
	typedef enum logic [1:0] {
		ACT_DATA    = 2'd0,
		ACT_START   = 2'd1,
		ACT_SUSPEND = 2'd2,
		ACT_PASS    = 2'd3
	} act_t;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_CAPACITY = 2'd0,
		REG_TRIGGER  = 2'd1,
		REG_CHUNK    = 2'd2,
		REG_RECEIVES = 2'd3
	} reg_idx_t;

	// Player mode, one-hot
	typedef enum logic [5:0] {
		M_STOP    = 6'b000001,
		M_READY   = 6'b000010,
		M_PRELOAD = 6'b000100,
		M_PLAY    = 6'b001000,
		M_DROP    = 6'b010000,
		M_FLUSH   = 6'b100000
	} mode_t;

	// Mode codes as seen on the result channel
	localparam logic [2:0] CODE_STOP    = 3'd0;
	localparam logic [2:0] CODE_READY   = 3'd1;
	localparam logic [2:0] CODE_PRELOAD = 3'd2;
	localparam logic [2:0] CODE_PLAY    = 3'd3;
	localparam logic [2:0] CODE_DROP    = 3'd4;
	localparam logic [2:0] CODE_FLUSH   = 3'd5;

	typedef struct packed {
		act_t        action;
		logic [15:0] byte_count;
	} evt_t;

	typedef struct packed {
		logic [2:0]  mode;
		logic [15:0] fill_level;
		logic [15:0] played_bytes;
		logic [31:0] dropped_total;
		logic        wake;
		logic        rejected;
	} res_t;

	typedef struct packed {
		reg_idx_t    index;
		logic [15:0] data;
	} cfg_wr_t;

	// Settings as used by the event logic
	typedef struct packed {
		logic [15:0]         cap_eff;
		logic [15:0]         trigger;
		logic [BUDGET_W-1:0] budget;
		logic [BUDGET_W-1:0] budget_less_one;
		logic                no_receives;
		logic                no_chunk;
	} cfg_t;

	function automatic logic [2:0] mode_code(input mode_t m);
		logic [2:0] c;
		unique case (m)
			M_STOP:    c = CODE_STOP;
			M_READY:   c = CODE_READY;
			M_PRELOAD: c = CODE_PRELOAD;
			M_PLAY:    c = CODE_PLAY;
			M_DROP:    c = CODE_DROP;
			M_FLUSH:   c = CODE_FLUSH;
			default:   c = CODE_STOP;
		endcase
		return c;
	endfunction

endpackage

### rtl/apbc_chan_if.sv
interface apbc_chan_if #(
	parameter type payload_t = logic
) ();

	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);

endinterface

### rtl/apbc_cfg_regs.sv
module apbc_cfg_regs import apbc_pkg::*; #(
	parameter int unsigned FILL_WIDTH = FILL_WIDTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	apbc_chan_if.sink  cfg,
	output cfg_t       settings
);

	// Largest fill the counter can hold, limited to the 16-bit capacity field
	localparam logic [15:0] CAP_LIM = (FILL_WIDTH >= 16) ? 16'hFFFF :
		16'((64'd1 << FILL_WIDTH) - 64'd1);

	logic [15:0]         capacity_q;
	logic [15:0]         trigger_q;
	logic [12:0]         chunk_q;
	logic [6:0]          receives_q;
	logic [BUDGET_W-1:0] budget_q;
	logic [BUDGET_W-1:0] budget_less_one_q;
	logic [BUDGET_W-1:0] product;

	// Writes are always taken
	assign cfg.ready = 1'b1;

	// Register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAPACITY_RST;
			trigger_q  <= TRIGGER_RST;
			chunk_q    <= CHUNK_RST;
			receives_q <= RECEIVES_RST;
		end else if (cfg.valid) begin
			unique case (cfg.payload.index)
				REG_CAPACITY: capacity_q <= cfg.payload.data;
				REG_TRIGGER:  trigger_q  <= cfg.payload.data;
				REG_CHUNK:    chunk_q    <= cfg.payload.data[12:0];
				REG_RECEIVES: receives_q <= cfg.payload.data[6:0];
			endcase
		end
	end

	// Per-pass drain budget, registered behind the multiplier
	assign product = BUDGET_W'(receives_q) * BUDGET_W'(chunk_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			budget_q          <= BUDGET_W'(RECEIVES_RST) * BUDGET_W'(CHUNK_RST);
			budget_less_one_q <= BUDGET_W'(RECEIVES_RST - 7'd1) * BUDGET_W'(CHUNK_RST);
		end else begin
			budget_q          <= product;
			budget_less_one_q <= product - BUDGET_W'(chunk_q);
		end
	end

	assign settings.cap_eff         = (capacity_q < CAP_LIM) ? capacity_q : CAP_LIM;
	assign settings.trigger         = trigger_q;
	assign settings.budget          = budget_q;
	assign settings.budget_less_one = budget_less_one_q;
	assign settings.no_receives     = (receives_q == 7'd0);
	assign settings.no_chunk        = (chunk_q == 13'd0);

endmodule

### rtl/apbc_core.sv
module apbc_core import apbc_pkg::*; #(
	parameter int unsigned FILL_WIDTH = FILL_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step_en,
	input  act_t        action,
	input  logic [15:0] byte_count,
	input  cfg_t        settings,
	output res_t        res
);

	// Common compare width for fill, budget and 16-bit fields
	localparam int unsigned CW = (FILL_WIDTH > BUDGET_W) ? FILL_WIDTH : BUDGET_W;

	mode_t                 mode_q, mode_d;
	logic [FILL_WIDTH-1:0] fill_q, fill_d;
	logic [31:0]           drop_q, drop_d;
	logic [31:0]           drop_base;
	logic [15:0]           drop_add;
	logic [32:0]           drop_sum;
	logic [CW-1:0]         fill_x, cap_x, size_x, trig_x, space_x, kept_x;
	logic [CW-1:0]         grown_x, played_x, rem_x;
	logic                  wake, rejected, left;

	assign fill_x  = CW'(fill_q);
	assign cap_x   = CW'(settings.cap_eff);
	assign size_x  = CW'(byte_count);
	assign trig_x  = CW'(settings.trigger);
	assign space_x = (fill_x < cap_x) ? cap_x - fill_x : '0;
	assign kept_x  = space_x & ~CW'(3);
	assign grown_x = fill_x + size_x;

	// Drain: whole budget or the whole fill, whichever is less; nothing with zero receives or chunk
	always_comb begin
		if (settings.no_receives || settings.no_chunk) begin
			played_x = '0;
		end else begin
			played_x = (fill_x < CW'(settings.budget)) ? fill_x : CW'(settings.budget);
		end
	end
	assign rem_x = fill_x - played_x;

	// Next state for one event
	always_comb begin
		mode_d    = mode_q;
		fill_d    = fill_q;
		drop_base = drop_q;
		drop_add  = '0;
		wake      = 1'b0;
		rejected  = 1'b0;
		left      = 1'b1;
		unique case (action)
			ACT_DATA: begin
				if (mode_q == M_DROP) begin
					drop_add = byte_count;
				end else if (mode_q == M_STOP) begin
					rejected = 1'b1;
				end else if (size_x < space_x) begin
					fill_d = FILL_WIDTH'(grown_x);
					if ((mode_q == M_READY || mode_q == M_PRELOAD) && grown_x >= trig_x) begin
						mode_d = M_PLAY;
						wake   = 1'b1;
					end else if (mode_q == M_READY) begin
						mode_d = M_PRELOAD;
					end
				end else begin
					// overflow: keep an aligned part, count the rest from zero
					wake      = (mode_q == M_PRELOAD);
					mode_d    = M_DROP;
					drop_base = '0;
					fill_d    = FILL_WIDTH'(fill_x + kept_x);
					drop_add  = 16'(size_x - kept_x);
				end
			end
			ACT_START: begin
				if (mode_q == M_STOP) begin
					mode_d = M_READY;
				end else if (mode_q == M_FLUSH) begin
					mode_d = M_PLAY;
				end
			end
			ACT_SUSPEND: begin
				if (mode_q != M_STOP) begin
					mode_d = M_FLUSH;
				end
			end
			ACT_PASS: begin
				if (mode_q == M_PLAY || mode_q == M_DROP || mode_q == M_FLUSH) begin
					if (settings.no_receives) begin
						left = 1'b1;
					end else if (settings.no_chunk) begin
						left = 1'b0;
					end else begin
						// the last receive finds nothing unless fill exceeds all but one chunk
						left = (fill_x > CW'(settings.budget_less_one));
					end
					fill_d = FILL_WIDTH'(rem_x);
					if (left) begin
						if (mode_q == M_DROP && rem_x < trig_x) begin
							mode_d = M_PLAY;
						end
					end else if (mode_q == M_FLUSH) begin
						mode_d = M_STOP;
						fill_d = '0;
					end else begin
						mode_d = M_READY;
					end
				end
			end
		endcase
		// saturating dropped-byte count
		drop_sum = {1'b0, drop_base} + {17'd0, drop_add};
		drop_d   = drop_sum[32] ? '1 : drop_sum[31:0];
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_STOP;
			fill_q <= '0;
			drop_q <= '0;
		end else if (step_en) begin
			mode_q <= mode_d;
			fill_q <= fill_d;
			drop_q <= drop_d;
		end
	end

	assign res.mode          = mode_code(mode_d);
	assign res.fill_level    = 16'(fill_d);
	assign res.played_bytes  = 16'(played_x & {CW{action == ACT_PASS && fill_d != fill_q}});
	assign res.dropped_total = drop_d;
	assign res.wake          = wake;
	assign res.rejected      = rejected;

	// Stop is only reached from reset or through a flush that clears the fill
	a_stop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == M_STOP |-> fill_q == '0)
		else $error("fill held while stopped");

	// Dropped count moves only by data events that end in drop mode
	a_drop_moves: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(drop_q) |-> mode_q == M_DROP && $past(step_en && action == ACT_DATA))
		else $error("dropped count moved outside drop mode");

	// Fill grows only by data events
	a_fill_grows: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q > $past(fill_q) |-> $past(step_en && action == ACT_DATA))
		else $error("fill grew without data");

	// Wake only with preload or ready left behind
	a_wake_mode: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && wake |=> mode_q == M_PLAY || mode_q == M_DROP)
		else $error("wake without play or drop");

endmodule

### rtl/audio_playout_buffer_control.sv
// Channel  Dir  Payload                                              Handshake
// evt      in   action, byte_count                                   valid/ready
// res      out  mode, fill_level, played_bytes, dropped_total,       valid/ready
//               wake, rejected
// cfg      in   index (0 capacity, 1 trigger, 2 chunk, 3 receives),  valid/ready (always ready)
//               data
//
// One event per cycle while res is taken. An event is held in the input register;
// the state and the result register update when it moves on.
// Reset: mode stop, fill and dropped count zero, registers at defaults.
// A stalled result holds in the result register; one more event waits in
// the input register, then evt.ready drops until res is taken.
// The drain budget is registered from the register file, in the cycle after a configuration write.
module audio_playout_buffer_control import apbc_pkg::*; #(
	parameter int unsigned FILL_WIDTH = FILL_WIDTH_DEF
) (
	input logic       clk,
	input logic       arst_n,
	apbc_chan_if.sink   evt,
	apbc_chan_if.source res,
	apbc_chan_if.sink   cfg
);

	logic        valid_s1;
	act_t        action_s1;
	logic [15:0] count_s1;
	logic        res_valid_q;
	res_t        res_q;
	res_t        core_res;
	cfg_t        settings;
	logic        advance;

	// Input register moves when the result register is free or drains
	assign advance   = valid_s1 && (!res_valid_q || res.ready);
	assign evt.ready = !valid_s1 || advance;

	apbc_cfg_regs #(
		.FILL_WIDTH (FILL_WIDTH)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.settings (settings)
	);

	apbc_core #(
		.FILL_WIDTH (FILL_WIDTH)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step_en    (advance),
		.action     (action_s1),
		.byte_count (count_s1),
		.settings   (settings),
		.res        (core_res)
	);

	// Input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (evt.valid && evt.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input register payload
	always_ff @(posedge clk) begin
		if (evt.valid && evt.ready) begin
			action_s1 <= evt.payload.action;
			count_s1  <= evt.payload.byte_count;
		end
	end

	// Result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= core_res;
		end
	end

	assign res.valid   = res_valid_q;
	assign res.payload = res_q;

endmodule

### tb/sv/testbench.sv
module testbench;
	import apbc_pkg::*;

	localparam int unsigned STALL_LIMIT = 3000;  // cycles with no transfer before giving up
	localparam int unsigned HOLD_CYCLES = 300;   // long result-side hold-off
	localparam int unsigned DROP_EVENTS = 20;    // full-size data events while in drop mode

	// One row of the directed sequence: an event or a register write
	typedef struct {
		bit          is_wr;
		act_t        act;
		reg_idx_t    idx;
		logic [15:0] val;
		bit          typed;
		res_t        res;
	} step_t;

	// One register setting and the random traffic run under it
	typedef struct {
		logic [15:0] cap;
		logic [15:0] trig;
		logic [15:0] chunk;
		logic [15:0] recv;
		int          pct;
		int          items;
		bit          squeeze;
	} phase_t;

	logic clk;
	logic arst_n;

	apbc_chan_if #(.payload_t(evt_t))    evt_ch ();
	apbc_chan_if #(.payload_t(res_t))    res_ch ();
	apbc_chan_if #(.payload_t(cfg_wr_t)) cfg_ch ();

	audio_playout_buffer_control dut (
		.clk    (clk),
		.arst_n (arst_n),
		.evt    (evt_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	// Shadow registers and player state
	logic [15:0] cap_r;
	logic [15:0] trig_r;
	logic [12:0] chunk_r;
	logic [6:0]  recv_r;
	logic [2:0]  mode_r;
	logic [15:0] fill_r;
	logic [31:0] drop_r;

	res_t        awaited_res[$];
	step_t       steps[$];
	phase_t      phases[$];
	int          errors;
	int          n_events;
	int          n_results;
	int          n_settings;
	bit          saturated;
	int          idle_pct;
	bit          hold_req;
	int unsigned quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Saturating add for the dropped-byte count
	function automatic logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	// Applies one event to the shadow state and returns the result it gives
	function automatic res_t playout_step(evt_t e);
		res_t        r;
		int unsigned space;
		int unsigned kept;
		int unsigned take;
		int unsigned drained;
		int unsigned i;
		bit          left;
		r = '0;
		drained = 0;
		case (e.action)
			ACT_DATA: begin
				if (mode_r == CODE_DROP) begin
					drop_r = sat_add(drop_r, 32'(e.byte_count));
				end else if (mode_r == CODE_STOP) begin
					r.rejected = 1'b1;
				end else begin
					space = (fill_r < cap_r) ? 32'(cap_r - fill_r) : 32'd0;
					if (e.byte_count < space) begin
						fill_r = fill_r + e.byte_count;
						if (mode_r == CODE_READY)
							mode_r = CODE_PRELOAD;
						if (mode_r == CODE_PRELOAD && fill_r >= trig_r) begin
							mode_r = CODE_PLAY;
							r.wake = 1'b1;
						end
					end else begin
						// overflow: keep the aligned part of what still fits
						if (mode_r == CODE_PRELOAD)
							r.wake = 1'b1;
						mode_r = CODE_DROP;
						drop_r = '0;
						kept = space & ~32'd3;
						fill_r = fill_r + 16'(kept);
						drop_r = sat_add(drop_r, e.byte_count - kept);
					end
				end
			end
			ACT_START: begin
				if (mode_r == CODE_STOP)
					mode_r = CODE_READY;
				else if (mode_r == CODE_FLUSH)
					mode_r = CODE_PLAY;
			end
			ACT_SUSPEND: begin
				if (mode_r != CODE_STOP)
					mode_r = CODE_FLUSH;
			end
			ACT_PASS: begin
				if (mode_r >= CODE_PLAY) begin
					left = 1'b1;
					i = 0;
					while (left && i < 32'(recv_r)) begin
						take = (fill_r < 16'(chunk_r)) ? 32'(fill_r) : 32'(chunk_r);
						if (take == 0) begin
							left = 1'b0;
						end else begin
							fill_r = fill_r - 16'(take);
							drained = drained + take;
						end
						i++;
					end
					if (left) begin
						if (mode_r == CODE_DROP && fill_r < trig_r)
							mode_r = CODE_PLAY;
					end else if (mode_r == CODE_FLUSH) begin
						mode_r = CODE_STOP;
						fill_r = '0;
					end else begin
						mode_r = CODE_READY;
					end
				end
			end
		endcase
		if (drop_r == 32'hFFFF_FFFF)
			saturated = 1'b1;
		r.mode = mode_r;
		r.fill_level = fill_r;
		r.played_bytes = 16'(drained);
		r.dropped_total = drop_r;
		return r;
	endfunction

	task automatic report(string msg);
		errors++;
		$display("[%0t] mismatch: %s", $time, msg);
	endtask

	task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			report($sformatf("%s got %0d, expected %0d", name, got, want));
	endtask

	// Result monitor: compare each transfer with the oldest expectation
	always @(posedge clk) begin
		res_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (awaited_res.size() == 0) begin
				report("result transfer with nothing awaited");
			end else begin
				want = awaited_res.pop_front();
				n_results++;
				check_field("mode", res_ch.payload.mode, want.mode);
				check_field("fill_level", res_ch.payload.fill_level, want.fill_level);
				check_field("played_bytes", res_ch.payload.played_bytes, want.played_bytes);
				check_field("dropped_total", res_ch.payload.dropped_total,
					want.dropped_total);
				check_field("wake", res_ch.payload.wake, want.wake);
				check_field("rejected", res_ch.payload.rejected, want.rejected);
			end
		end
	end

	// Watchdog on cycles with no transfer on any channel
	always @(posedge clk) begin
		if (!arst_n || (evt_ch.valid && evt_ch.ready) || (res_ch.valid && res_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles, %0d results outstanding",
				quiet_cycles, awaited_res.size());
			$display("TEST FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Result-side ready: random stall bursts plus one long hold-off on request
	initial begin
		res_ch.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				res_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else if (idle_pct > 0 && $urandom_range(0, 399) < idle_pct) begin
				res_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(negedge clk);
			end else begin
				res_ch.ready <= 1'b1;
				@(negedge clk);
			end
		end
	end

	// Offer one event, wait for its transfer, then queue what it should give
	task automatic send_event(act_t a, logic [15:0] count, bit typed, res_t typed_res);
		evt_t e;
		res_t predicted;
		e = '{action: a, byte_count: count};
		if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
			@(negedge clk) evt_ch.valid <= 1'b0;
			repeat ($urandom_range(0, 13)) @(negedge clk);
		end
		@(negedge clk);
		evt_ch.valid <= 1'b1;
		evt_ch.payload <= e;
		@(posedge clk);
		while (!evt_ch.ready) @(posedge clk);
		predicted = playout_step(e);
		awaited_res.push_back(typed ? typed_res : predicted);
		n_events++;
	endtask

	// Stop offering and let every awaited result come out
	task automatic wait_idle();
		@(negedge clk) evt_ch.valid <= 1'b0;
		while (awaited_res.size() != 0) @(posedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [15:0] v);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.payload <= '{index: idx, data: v};
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		case (idx)
			REG_CAPACITY: cap_r = v;
			REG_TRIGGER:  trig_r = v;
			REG_CHUNK:    chunk_r = v[12:0];
			REG_RECEIVES: recv_r = v[6:0];
		endcase
		@(negedge clk) cfg_ch.valid <= 1'b0;
	endtask

	task automatic apply_setting(phase_t p);
		wait_idle();
		write_reg(REG_CAPACITY, p.cap);
		write_reg(REG_TRIGGER, p.trig);
		write_reg(REG_CHUNK, p.chunk);
		write_reg(REG_RECEIVES, p.recv);
		n_settings++;
	endtask

	// Mostly start/data/pass traffic, sizes scaled to the buffer and its free space
	task automatic random_events(int count);
		act_t        a;
		logic [15:0] v;
		int unsigned room;
		int          roll;
		int          k;
		for (k = 0; k < count; k++) begin
			roll = $urandom_range(0, 99);
			if (mode_r == CODE_STOP && roll < 80)
				a = ACT_START;
			else if (roll < 45)
				a = ACT_DATA;
			else if (roll < 82)
				a = ACT_PASS;
			else if (roll < 91)
				a = ACT_START;
			else
				a = ACT_SUSPEND;
			room = (fill_r < cap_r) ? 32'(cap_r - fill_r) : 32'd0;
			case ($urandom_range(0, 9))
				0: v = '0;
				1: v = 16'hFFFF;
				2: v = 16'($urandom);
				3: v = 16'(room - $urandom_range(0, 1));
				4: v = 16'(room + $urandom_range(0, 3));
				default: v = 16'($urandom_range(0, cap_r / 4 + 1));
			endcase
			send_event(a, v, 1'b0, '0);
		end
	endtask

	function automatic step_t ev(act_t a, logic [15:0] v);
		step_t s;
		s.is_wr = 1'b0;
		s.act = a;
		s.idx = REG_CAPACITY;
		s.val = v;
		s.typed = 1'b0;
		s.res = '0;
		return s;
	endfunction

	function automatic step_t evx(act_t a, logic [15:0] v, logic [2:0] m, logic [15:0] f,
			logic w, logic rj);
		step_t s;
		s = ev(a, v);
		s.typed = 1'b1;
		s.res = '{mode: m, fill_level: f, played_bytes: '0, dropped_total: '0,
			wake: w, rejected: rj};
		return s;
	endfunction

	function automatic step_t wr(reg_idx_t ix, logic [15:0] v);
		step_t s;
		s = ev(ACT_DATA, v);
		s.is_wr = 1'b1;
		s.idx = ix;
		return s;
	endfunction

	initial begin
		phase_t p;
		evt_ch.valid = 1'b0;
		evt_ch.payload = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.payload = '0;
		arst_n = 1'b0;
		idle_pct = 0;
		hold_req = 1'b0;
		errors = 0;
		n_events = 0;
		n_results = 0;
		n_settings = 1;
		saturated = 1'b0;
		quiet_cycles = 0;
		cap_r = CAPACITY_RST;
		trig_r = TRIGGER_RST;
		chunk_r = CHUNK_RST;
		recv_r = RECEIVES_RST;
		mode_r = CODE_STOP;
		fill_r = '0;
		drop_r = '0;

		// Directed sequence, starting from the reset settings
		steps.push_back(evx(ACT_DATA, 16'hFFFF, CODE_STOP, 16'd0, 1'b0, 1'b1));
		steps.push_back(evx(ACT_PASS, 16'd0, CODE_STOP, 16'd0, 1'b0, 1'b0));
		steps.push_back(evx(ACT_SUSPEND, 16'd0, CODE_STOP, 16'd0, 1'b0, 1'b0));
		steps.push_back(evx(ACT_START, 16'd0, CODE_READY, 16'd0, 1'b0, 1'b0));
		steps.push_back(evx(ACT_DATA, 16'd0, CODE_PRELOAD, 16'd0, 1'b0, 1'b0));
		steps.push_back(ev(ACT_DATA, 16'd8191));
		steps.push_back(evx(ACT_DATA, 16'd1, CODE_PLAY, 16'd8192, 1'b1, 1'b0));
		steps.push_back(ev(ACT_PASS, 16'd0));
		steps.push_back(ev(ACT_DATA, 16'hFFFF));     // overflow into drop
		steps.push_back(ev(ACT_DATA, 16'hFFFF));     // all counted as dropped
		steps.push_back(ev(ACT_PASS, 16'd0));
		steps.push_back(ev(ACT_START, 16'd0));
		steps.push_back(ev(ACT_SUSPEND, 16'd0));
		steps.push_back(wr(REG_CHUNK, 16'd0));
		steps.push_back(ev(ACT_PASS, 16'd0));        // zero chunk empties, flush stops
		steps.push_back(wr(REG_CAPACITY, 16'd8));
		steps.push_back(wr(REG_TRIGGER, 16'd0));
		steps.push_back(wr(REG_CHUNK, 16'd4096));
		steps.push_back(wr(REG_RECEIVES, 16'd0));
		steps.push_back(ev(ACT_START, 16'd0));
		steps.push_back(ev(ACT_DATA, 16'd3));        // preload reaches trigger at once
		steps.push_back(ev(ACT_PASS, 16'd0));        // no receives: data left
		steps.push_back(ev(ACT_DATA, 16'd8));        // partial keep, aligned to 4
		steps.push_back(ev(ACT_SUSPEND, 16'd0));
		steps.push_back(ev(ACT_START, 16'd0));       // flush back to play
		steps.push_back(wr(REG_CAPACITY, 16'd4));    // fill now above capacity
		steps.push_back(ev(ACT_DATA, 16'd2));
		steps.push_back(wr(REG_RECEIVES, 16'd1));
		steps.push_back(ev(ACT_PASS, 16'd0));        // empties on the last receive
		steps.push_back(ev(ACT_PASS, 16'd0));        // empty buffer: ready

		phases.push_back('{16'd64, 16'd16, 16'd4, 16'd2, 25, 110, 1'b0});
		phases.push_back('{16'd4, 16'd0, 16'd1, 16'd1, 10, 100, 1'b0});
		phases.push_back('{16'd65535, 16'd65535, 16'd4096, 16'd64, 0, 110, 1'b0});
		phases.push_back('{16'd1000, 16'd600, 16'd100, 16'd3, 20, 110, 1'b1});
		phases.push_back('{16'd200, 16'd150, 16'd0, 16'd5, 35, 90, 1'b0});
		phases.push_back('{16'd300, 16'd100, 16'd50, 16'd0, 15, 90, 1'b0});
		phases.push_back('{16'd40, 16'd100, 16'd8, 16'd3, 25, 110, 1'b0});

		repeat (10) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		idle_pct = 15;
		foreach (steps[i]) begin
			if (steps[i].is_wr) begin
				wait_idle();
				write_reg(steps[i].idx, steps[i].val);
			end else begin
				send_event(steps[i].act, steps[i].val, steps[i].typed, steps[i].res);
			end
		end
		n_settings++;

		// Random traffic under each setting
		foreach (phases[i]) begin
			apply_setting(phases[i]);
			idle_pct = phases[i].pct;
			if (phases[i].squeeze)
				hold_req = 1'b1;
			random_events(phases[i].items);
		end

		// Last part: no idling; a run of full-size data events in drop mode, then random traffic at reset settings
		idle_pct = 0;
		p = '{16'd4, 16'd0, 16'd1, 16'd1, 0, 0, 1'b0};
		apply_setting(p);
		if (mode_r == CODE_STOP)
			send_event(ACT_START, 16'd0, 1'b0, '0);
		if (mode_r != CODE_DROP)
			send_event(ACT_DATA, 16'hFFFF, 1'b0, '0);
		repeat (DROP_EVENTS) send_event(ACT_DATA, 16'hFFFF, 1'b0, '0);
		p = '{16'd16384, 16'd8192, 16'd512, 16'd4, 0, 0, 1'b0};
		apply_setting(p);
		random_events(40);

		wait_idle();
		repeat (8) @(posedge clk);
		$display("Run covered %0d events under %0d register settings, %0d results compared.",
			n_events, n_settings, n_results);
		$display("Dropped-byte count saturation %s reached; %0d mismatches.",
			saturated ? "was" : "was not", errors);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

### files.f
rtl/apbc_pkg.sv
rtl/apbc_chan_if.sv
rtl/apbc_cfg_regs.sv
rtl/apbc_core.sv
rtl/audio_playout_buffer_control.sv
tb/sv/testbench.sv
